### rtl/core/pcm_pkg.sv
// shared types and constants of the pixel color math block
package pcm_pkg;

	localparam int unsigned COLOR_W   = 15;
	localparam int unsigned CHAN_W    = 5;
	localparam int unsigned NUM_CHAN  = 3;
	localparam int unsigned SRC_W     = 3;
	localparam int unsigned LAYERS    = 6;
	localparam int unsigned BRIGHT_W  = 4;
	localparam int unsigned WORD_W    = BRIGHT_W + COLOR_W;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 15;

	localparam logic [SRC_W-1:0]  LAYER_BACKDROP = 3'd5;
	localparam logic [CHAN_W-1:0] CHAN_MAX       = 5'd31;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_ENABLE   = 3'd0,
		REG_BLEND_WITH_SUB = 3'd1,
		REG_HALVE_ENABLE   = 3'd2,
		REG_SUBTRACT_MODE  = 3'd3,
		REG_FIXED_COLOR    = 3'd4,
		REG_BRIGHTNESS     = 3'd5,
		REG_HIRES_MODE     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [LAYERS-1:0]   color_enable;
		logic                blend_with_sub;
		logic                halve_enable;
		logic                subtract_mode;
		logic [COLOR_W-1:0]  fixed_color;
		logic [BRIGHT_W-1:0] brightness;
		logic                hires_mode;
	} cfg_t;

	// one pixel with the layer it came from
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [SRC_W-1:0]   source;
	} pix_t;

endpackage

### rtl/core/pcm_cfg.sv
// configuration register file of the pixel color math block
module pcm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcm_pkg::CFG_DAT_W-1:0]  cfg_data,
	output pcm_pkg::cfg_t                  cfg
);

	pcm_pkg::cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcm_pkg::REG_COLOR_ENABLE: begin
					cfg_q.color_enable <= cfg_data[pcm_pkg::LAYERS-1:0];
				end
				pcm_pkg::REG_BLEND_WITH_SUB: begin
					cfg_q.blend_with_sub <= cfg_data[0];
				end
				pcm_pkg::REG_HALVE_ENABLE: begin
					cfg_q.halve_enable <= cfg_data[0];
				end
				pcm_pkg::REG_SUBTRACT_MODE: begin
					cfg_q.subtract_mode <= cfg_data[0];
				end
				pcm_pkg::REG_FIXED_COLOR: begin
					cfg_q.fixed_color <= cfg_data[pcm_pkg::COLOR_W-1:0];
				end
				pcm_pkg::REG_BRIGHTNESS: begin
					cfg_q.brightness <= cfg_data[pcm_pkg::BRIGHT_W-1:0];
				end
				pcm_pkg::REG_HIRES_MODE: begin
					cfg_q.hires_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/pcm_shade.sv
// window, enable and per-channel blend logic for one front pixel
module pcm_shade (
	input  pcm_pkg::cfg_t                 cfg,
	input  pcm_pkg::pix_t                 front,
	input  pcm_pkg::pix_t                 back,
	input  logic                          win_main,
	input  logic                          win_sub,
	output logic [pcm_pkg::COLOR_W-1:0]   color
);

	logic [pcm_pkg::COLOR_W-1:0] front_c;
	logic [pcm_pkg::COLOR_W-1:0] other_c;
	logic [pcm_pkg::COLOR_W-1:0] mixed_c;
	logic                        layer_on;
	logic                        halve;

	// blacking by the main window
	assign front_c = win_main ? front.color : '0;

	// layer enable, layers above the backdrop have no bit
	always_comb begin
		layer_on = 1'b0;
		if (front.source < pcm_pkg::SRC_W'(pcm_pkg::LAYERS)) begin
			layer_on = cfg.color_enable[front.source];
		end
	end

	// blend operand and halving permission
	assign other_c = cfg.blend_with_sub ? back.color : cfg.fixed_color;
	assign halve   = cfg.halve_enable && win_main &&
	                 (!cfg.blend_with_sub || (back.source != pcm_pkg::LAYER_BACKDROP));

	// per-channel saturating add or clamped subtract
	always_comb begin
		logic [pcm_pkg::CHAN_W-1:0] ca;
		logic [pcm_pkg::CHAN_W-1:0] cb;
		logic [pcm_pkg::CHAN_W:0]   sum;
		logic [pcm_pkg::CHAN_W-1:0] dif;
		logic [pcm_pkg::CHAN_W-1:0] res;
		mixed_c = '0;
		for (int unsigned ch = 0; ch < pcm_pkg::NUM_CHAN; ch++) begin
			ca  = front_c[ch*pcm_pkg::CHAN_W +: pcm_pkg::CHAN_W];
			cb  = other_c[ch*pcm_pkg::CHAN_W +: pcm_pkg::CHAN_W];
			sum = {1'b0, ca} + {1'b0, cb};
			dif = (ca > cb) ? (ca - cb) : '0;
			if (!cfg.subtract_mode) begin
				if (halve) begin
					res = sum[pcm_pkg::CHAN_W:1];
				end else if (sum[pcm_pkg::CHAN_W]) begin
					res = pcm_pkg::CHAN_MAX;
				end else begin
					res = sum[pcm_pkg::CHAN_W-1:0];
				end
			end else begin
				res = halve ? (dif >> 1) : dif;
			end
			mixed_c[ch*pcm_pkg::CHAN_W +: pcm_pkg::CHAN_W] = res;
		end
	end

	// pass through when math is off at this pixel
	assign color = (win_sub && layer_on) ? mixed_c : front_c;

endmodule

### rtl/core/pixel_color_math.sv
// pixel color math top level: input register, shade logic, result register
//
// Input channel: in_valid / in_stall with main and sub pixel, their layers
// and the two window bits. A request is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with output_word
// (brightness over the 15-bit color) and last.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while the block is idle.
// Data path: an accepted request is held in the input register, where the shade
// logic works on it; its first result is loaded into the output register when
// that register is free or being emptied, and is taken from there.
// Throughput: one request per cycle while out_stall is low. In hires mode each
// request gives two results (swapped roles first, then normal with last set)
// and holds the input register until both went through the single result port.
// Reset clears both registers' valid flags and all configuration to zero.
// While out_stall is high the result holds; the input register keeps its
// request, and in_stall rises once it cannot move on.
module pixel_color_math (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pcm_pkg::COLOR_W-1:0]    main_color,
	input  logic [pcm_pkg::SRC_W-1:0]      main_source,
	input  logic [pcm_pkg::COLOR_W-1:0]    sub_color,
	input  logic [pcm_pkg::SRC_W-1:0]      sub_source,
	input  logic                           window_main,
	input  logic                           window_sub,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pcm_pkg::WORD_W-1:0]     output_word,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcm_pkg::CFG_DAT_W-1:0]  cfg_data
);

	pcm_pkg::cfg_t                cfg;
	pcm_pkg::pix_t                main_s1;
	pcm_pkg::pix_t                sub_s1;
	logic                         wmain_s1;
	logic                         wsub_s1;
	logic                         valid_s1;
	logic                         phase_q;
	logic                         swap;
	pcm_pkg::pix_t                front;
	pcm_pkg::pix_t                back;
	logic [pcm_pkg::COLOR_W-1:0]  color;
	logic                         out_load;
	logic                         s1_free;
	logic                         in_take;
	logic                         out_valid_q;
	logic [pcm_pkg::WORD_W-1:0]   word_q;
	logic                         last_q;

	pcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake between input register and result register
	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_free  = out_load && (!cfg.hires_mode || phase_q);
	assign in_stall = valid_s1 && !s1_free;
	assign in_take  = in_valid && !in_stall;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_free) begin
				valid_s1 <= 1'b0;
			end
			if (s1_free) begin
				phase_q <= 1'b0;
			end else if (out_load) begin
				phase_q <= 1'b1;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			main_s1  <= '{color: main_color, source: main_source};
			sub_s1   <= '{color: sub_color, source: sub_source};
			wmain_s1 <= window_main;
			wsub_s1  <= window_sub;
		end
	end

	// role select, sub pixel in front on the first hires result
	assign swap  = cfg.hires_mode && !phase_q;
	assign front = swap ? sub_s1 : main_s1;
	assign back  = swap ? main_s1 : sub_s1;

	pcm_shade u_shade (
		.cfg      (cfg),
		.front    (front),
		.back     (back),
		.win_main (wmain_s1),
		.win_sub  (wsub_s1),
		.color    (color)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			word_q <= {cfg.brightness, color};
			last_q <= !swap;
		end
	end

	assign out_valid   = out_valid_q;
	assign output_word = word_q;
	assign last        = last_q;

`ifndef SYNTH
	// second phase only exists for a held hires request
	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_s1 && cfg.hires_mode))
		else $error("phase set without a held hires request");

	// normal mode only stalls input behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !cfg.hires_mode) |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// a swapped result is followed right away by its closing result
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last && !out_stall) |=> (out_valid && last))
		else $error("hires result pair broken");

	// without hires every result closes its request
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg.hires_mode) |-> last)
		else $error("non-final result outside hires mode");
`endif

endmodule
